FILE: hdl/chained_hash_dictionary_top_macros.svh
// Assertion macros for the chained hash dictionary.
`ifndef CHAINED_HASH_DICTIONARY_TOP_MACROS_SVH
`define CHAINED_HASH_DICTIONARY_TOP_MACROS_SVH

// Concurrent assertion: when the antecedent holds, the consequent holds in the same cycle.
`define CHD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Concurrent assertion: when the antecedent holds, the consequent holds in the next cycle.
`define CHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/chd_pkg.sv
package chd_pkg;

  localparam int Buckets = 10;
  localparam int PoolEntries = 16;
  localparam int LinkW = $clog2(PoolEntries + 1);
  localparam int NodeW = $clog2(PoolEntries);
  localparam int BucketW = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int StepW = $clog2(PoolEntries + 1);
  localparam logic [LinkW-1:0] NullLink = LinkW'(PoolEntries);

  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StMissing  = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StNotDigit = 2'd3;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  typedef struct packed {
    logic        mode;
    logic [31:0] key;
    logic [31:0] payload;
  } chd_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] node_slot;
    logic [4:0] entry_count;
  } chd_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic walk_start;
    logic walk_step;
    logic do_insert;
    logic do_unlink;
    logic [1:0] emit_status;
    logic emit;
  } chd_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic not_digit;
    logic mode;
    logic pool_empty;
    logic cur_is_node;
    logic match;
    logic steps_done;
  } chd_stat_t;

  // The digit selects its bucket through a small constant table.
  function automatic logic [BucketW-1:0] bucket_of(input logic [7:0] ch);
    logic [3:0]         d;
    logic [BucketW-1:0] r;
    d = 4'(ch - CharZero);
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (d == 4'(i)) begin
        r = BucketW'(i % Buckets);
      end
    end
    return r;
  endfunction

endpackage

FILE: hdl/chained_hash_dictionary_top.sv
// Chained hash dictionary: accepts one insert or delete transaction at a time and returns
// one result per transaction. Insert, pool-full and non-digit transactions are decided in
// the decode state, which registers their result. A delete walks its bucket's chain and
// reports found or not found after visiting at most 16 nodes; the walk reads one node key
// from the pool memory per step and checks it after a wait state. The next transaction
// is accepted as soon as the result is registered, even while the result waits to be
// taken; its own result is held back until the previous one has been taken.
module chained_hash_dictionary_top import chd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  chd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output chd_out_t out_data
);

  chd_cmd_t  cmd;
  chd_stat_t stat;

  chd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_busy (out_valid && !out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  chd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/chd_ctrl.sv
module chd_ctrl import chd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_busy,
  input  chd_stat_t stat,
  output chd_cmd_t  cmd
);

  typedef enum logic [2:0] {SIdle, SDecode, SWalk, SCheck, SWait} state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == SIdle);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      SIdle: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = SDecode;
        end
      end
      SDecode: begin
        if (!out_busy) begin
          if (stat.not_digit) begin
            cmd.emit = 1'b1;
            cmd.emit_status = StNotDigit;
            state_nxt = SIdle;
          end else if (!stat.mode) begin
            cmd.emit = 1'b1;
            if (stat.pool_empty) begin
              cmd.emit_status = StFull;
            end else begin
              cmd.do_insert = 1'b1;
              cmd.emit_status = StDone;
            end
            state_nxt = SIdle;
          end else begin
            cmd.walk_start = 1'b1;
            state_nxt = SWait;
          end
        end
      end
      SWait: begin
        state_nxt = SCheck;
      end
      SCheck: begin
        if (!stat.cur_is_node || stat.steps_done) begin
          cmd.emit = 1'b1;
          cmd.emit_status = StMissing;
          state_nxt = SIdle;
        end else if (stat.match) begin
          cmd.emit = 1'b1;
          cmd.do_unlink = 1'b1;
          cmd.emit_status = StDone;
          state_nxt = SIdle;
        end else begin
          cmd.walk_step = 1'b1;
          state_nxt = SWalk;
        end
      end
      SWalk: begin
        state_nxt = SCheck;
      end
      default: state_nxt = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SIdle;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/chd_datapath.sv
module chd_datapath import chd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  chd_in_t   in_data,
  input  chd_cmd_t  cmd,
  output chd_stat_t stat,
  input  logic      out_ready,
  output logic      out_valid,
  output chd_out_t  out_data
);

  logic [LinkW-1:0] bucket_head_r [Buckets];
  logic [LinkW-1:0] next_link_r [PoolEntries];
  logic [31:0]      key_mem [PoolEntries];
  logic [31:0]      payload_mem [PoolEntries];
  logic [LinkW-1:0] free_head_r;
  logic [4:0]       entry_total_r;

  chd_in_t          item_r;
  logic [BucketW-1:0] bkt_r;
  logic [LinkW-1:0] cur_r, prev_r;
  logic [StepW-1:0] steps_r;
  logic [31:0]      rd_key_r;
  logic             out_valid_r;
  chd_out_t         out_r;

  logic [NodeW-1:0] cur_idx, free_idx, prev_idx;
  logic [LinkW-1:0] cur_next;

  assign cur_idx  = cur_r[NodeW-1:0];
  assign free_idx = free_head_r[NodeW-1:0];
  assign prev_idx = prev_r[NodeW-1:0];
  assign cur_next = next_link_r[cur_idx];

  assign stat.not_digit   = (item_r.key[7:0] < CharZero) || (item_r.key[7:0] > CharNine);
  assign stat.mode        = item_r.mode;
  assign stat.pool_empty  = (free_head_r >= NullLink);
  assign stat.cur_is_node = (cur_r < NullLink);
  assign stat.match       = (rd_key_r == item_r.key);
  assign stat.steps_done  = (steps_r >= StepW'(PoolEntries));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      bkt_r  <= bucket_of(in_data.key[7:0]);
    end
    if (cmd.walk_start || cmd.walk_step) begin
      rd_key_r <= key_mem[cmd.walk_start ? bucket_head_r[bkt_r][NodeW-1:0] : cur_next[NodeW-1:0]];
    end
    if (cmd.walk_start) begin
      cur_r   <= bucket_head_r[bkt_r];
      prev_r  <= NullLink;
      steps_r <= '0;
    end else if (cmd.walk_step) begin
      prev_r  <= cur_r;
      cur_r   <= cur_next;
      steps_r <= steps_r + StepW'(1);
    end
    if (cmd.do_insert) begin
      key_mem[free_idx]     <= item_r.key;
      payload_mem[free_idx] <= item_r.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Buckets; i++) begin
        bucket_head_r[i] <= NullLink;
      end
      for (int i = 0; i < PoolEntries; i++) begin
        next_link_r[i] <= (i == 0) ? NullLink : LinkW'(i - 1);
      end
      free_head_r   <= LinkW'(PoolEntries - 1);
      entry_total_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.do_insert) begin
        free_head_r            <= next_link_r[free_idx];
        next_link_r[free_idx]  <= bucket_head_r[bkt_r];
        bucket_head_r[bkt_r]   <= free_head_r;
        entry_total_r          <= entry_total_r + 5'd1;
      end
      if (cmd.do_unlink) begin
        if (prev_r < NullLink) begin
          next_link_r[prev_idx] <= cur_next;
        end else begin
          bucket_head_r[bkt_r] <= cur_next;
        end
        next_link_r[cur_idx] <= free_head_r;
        free_head_r          <= cur_r;
        if (entry_total_r != 5'd0) begin
          entry_total_r <= entry_total_r - 5'd1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.status <= cmd.emit_status;
      if (cmd.do_insert) begin
        out_r.node_slot   <= 4'(free_head_r);
        out_r.entry_count <= entry_total_r + 5'd1;
      end else if (cmd.do_unlink) begin
        out_r.node_slot   <= 4'(cur_r);
        out_r.entry_count <= (entry_total_r != 5'd0) ? entry_total_r - 5'd1 : 5'd0;
      end else begin
        out_r.node_slot   <= 4'd0;
        out_r.entry_count <= entry_total_r;
      end
    end
  end

  `include "chained_hash_dictionary_top_macros.svh"

  `CHD_ASSERT_IMP(a_insert_has_node, clk, rst_n, cmd.do_insert, free_head_r < NullLink, "insert with empty pool")
  `CHD_ASSERT_IMP(a_unlink_valid, clk, rst_n, cmd.do_unlink, cur_r < NullLink, "unlink of null node")
  `CHD_ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, out_valid_r, "result not presented")

endmodule

FILE: dv/chained_hash_dictionary_top_test.sv
`timescale 1ns / 1ps

module chained_hash_dictionary_top_test;
  import chd_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  chd_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  chd_out_t out_data;

  chained_hash_dictionary_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  chd_in_t  pending_ops[$];
  chd_out_t expected_results[$];
  int       error_count;
  int       send_idle_pct;
  int       recv_stall_pct;
  logic     stimulus_done;

  // Dictionary shadow state.
  logic [LinkW-1:0] dict_head[Buckets];
  logic [LinkW-1:0] dict_next[PoolEntries];
  logic [31:0]      dict_key[PoolEntries];
  logic [LinkW-1:0] dict_free;
  logic [4:0]       dict_total;
  logic [31:0]      live_keys[$];

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic reset_dictionary();
    for (int i = 0; i < Buckets; i++) dict_head[i] = NullLink;
    for (int i = 0; i < PoolEntries; i++)
      dict_next[i] = (i == 0) ? NullLink : LinkW'(i - 1);
    dict_free  = LinkW'(PoolEntries - 1);
    dict_total = '0;
  endtask

  function automatic chd_out_t predict_dictionary(input chd_in_t op);
    chd_out_t         res;
    logic [7:0]       last;
    int               b;
    logic [LinkW-1:0] node;
    logic [LinkW-1:0] prev;
    last = op.key[7:0];
    res.status = StNotDigit;
    res.node_slot = '0;
    if (last >= CharZero && last <= CharNine) begin
      b = (last - CharZero) % Buckets;
      if (op.mode == 1'b0) begin
        node = dict_free;
        if (node >= PoolEntries) begin
          res.status = StFull;
        end else begin
          dict_free = dict_next[node];
          dict_key[node] = op.key;
          dict_next[node] = dict_head[b];
          dict_head[b] = node;
          dict_total++;
          res.status = StDone;
          res.node_slot = node[3:0];
        end
      end else begin
        res.status = StMissing;
        prev = NullLink;
        node = dict_head[b];
        for (int s = 0; s < PoolEntries && node < PoolEntries; s++) begin
          if (dict_key[node] == op.key) begin
            if (prev < PoolEntries) dict_next[prev] = dict_next[node];
            else dict_head[b] = dict_next[node];
            dict_next[node] = dict_free;
            dict_free = node;
            if (dict_total > 0) dict_total--;
            res.status = StDone;
            res.node_slot = node[3:0];
            break;
          end
          prev = node;
          node = dict_next[node];
        end
      end
    end
    res.entry_count = dict_total;
    return res;
  endfunction

  function automatic logic [31:0] digit_key(input int digit);
    logic [31:0] k;
    k = $urandom;
    k[7:0] = CharZero + 8'(digit);
    return k;
  endfunction

  task automatic queue_op(input logic m, input logic [31:0] k, input logic [31:0] p);
    chd_in_t op;
    op.mode = m;
    op.key = k;
    op.payload = p;
    pending_ops.push_back(op);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_dictionary(in_data));
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    chd_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_data, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status != want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.node_slot != want.node_slot)
            report_mismatch("node_slot", out_data.node_slot, want.node_slot);
          if (out_data.entry_count != want.entry_count)
            report_mismatch("entry_count", out_data.entry_count, want.entry_count);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic drain_phase();
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic fill_random(input int count);
    logic [31:0] k;
    int          idx;
    int          roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        k = digit_key($urandom_range(9));
        if ($urandom_range(3) == 0) k[31:8] = {3{8'h30 + 8'($urandom_range(3))}};
        queue_op(1'b0, k, $urandom);
        live_keys.push_back(k);
      end else if (roll < 80 && live_keys.size() > 0) begin
        idx = $urandom_range(live_keys.size() - 1);
        queue_op(1'b1, live_keys[idx], $urandom);
        live_keys.delete(idx);
      end else if (roll < 92) begin
        queue_op(1'b1, digit_key($urandom_range(9)), $urandom);
      end else begin
        queue_op($urandom_range(1), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    stimulus_done = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_data = '0;
    reset_dictionary();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    queue_op(1'b1, 32'h3030_3035, 32'h0);
    queue_op(1'b0, 32'h0000_002F, 32'hFFFF_FFFF);
    queue_op(1'b1, 32'hFFFF_FF3A, 32'h0);
    queue_op(1'b0, 32'hFFFF_FFFF, 32'h0);
    queue_op(1'b0, 32'h0000_0030, 32'h0);
    queue_op(1'b0, 32'hFFFF_FF39, 32'hFFFF_FFFF);
    for (int i = 0; i < 15; i++) queue_op(1'b0, {24'hAB_CD00 + 24'(i), 8'h37}, 32'(i));
    queue_op(1'b0, 32'h1234_5633, 32'h5555_5555);
    queue_op(1'b1, {24'hAB_CD00, 8'h37}, 32'h0);
    queue_op(1'b0, 32'h3131_3137, 32'h0);
    queue_op(1'b0, 32'h3131_3137, 32'h1);
    queue_op(1'b1, 32'h3131_3137, 32'h0);
    queue_op(1'b1, 32'h3131_3137, 32'h0);
    drain_phase();

    for (int i = 0; i < 16; i++) queue_op(1'b1, {24'hAB_CD00 + 24'(i), 8'h37}, 32'h0);
    queue_op(1'b1, 32'hFFFF_FF39, 32'h0);
    queue_op(1'b1, 32'h0000_0030, 32'h0);
    queue_op(1'b1, 32'h1234_5633, 32'h0);
    drain_phase();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      fill_random(200);
      drain_phase();
    end
    repeat (60) @(posedge clk);
    stimulus_done = 1'b1;
    if (error_count == 0) begin
      $display("chained_hash_dictionary_top_test passed");
    end else begin
      $display("chained_hash_dictionary_top_test failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("chained_hash_dictionary_top_test failed");
    $finish;
  end

endmodule
